>>> hw/rtl/sbir_pkg.sv
// shared types and constants for the serial boot image receiver
package sbir_pkg;

    localparam int unsigned ADDR_DIGITS  = 8;
    localparam int unsigned SIZE_DIGITS  = 8;
    localparam int unsigned CNT_W        = 4;
    localparam int unsigned SIZE_W       = 27;
    localparam int unsigned ADDR_W       = 32;
    localparam int unsigned CFG_W        = 32;
    localparam int unsigned CFG_IDX_W    = 2;
    localparam int unsigned RES_DEPTH    = 4;
    localparam int unsigned RES_PTR_W    = 2;
    localparam int unsigned RES_CNT_W    = 3;

    localparam logic [ADDR_W-1:0] RELOC_DEFAULT = 32'h0060_0000;
    localparam logic [7:0]        CHAR_LF       = 8'h0A;

    typedef enum logic [1:0] {
        PH_ADDR  = 2'd0,
        PH_SIZE  = 2'd1,
        PH_IMAGE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        EV_ECHO  = 2'd0,
        EV_WRITE = 2'd1,
        EV_ERROR = 2'd2,
        EV_START = 2'd3
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RES_START = 2'd0,
        CFG_RES_END   = 2'd1,
        CFG_RELOC     = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        event_t              kind;
        logic [7:0]          data;
        logic [ADDR_W-1:0]   addr;
        logic                rel;
        logic                last;
    } result_t;

endpackage

>>> hw/rtl/serial_boot_image_receiver_top.sv
// serial boot image receiver: address/size parser, image write stream, result queue
// results are written into the result queue registers and reach the result ports from there
// throughput: one byte per cycle while in_stall is low; a byte giving two results
//   queues both, and input stalls when the 4-entry result queue has < 2 free
// reset: rst_n clears phase, accumulators, config (relocate base to 0x600000)
//   and the result queue; queue entries carry no reset
module serial_boot_image_receiver_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [sbir_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbir_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    rx_byte,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    event_kind,
    output logic [7:0]                    data_byte,
    output logic [sbir_pkg::ADDR_W-1:0]   target_addr,
    output logic                          relocated,
    output logic                          last_of_run
);
    import sbir_pkg::*;

    // configuration registers
    logic [ADDR_W-1:0] res_start_reg;
    logic [ADDR_W-1:0] res_end_reg;
    logic [ADDR_W-1:0] reloc_reg;

    // parser state
    phase_t            phase_reg,  phase_next;
    logic [CNT_W-1:0]  cnt_reg,    cnt_next;
    logic [ADDR_W-1:0] addr_reg,   addr_next;
    logic [SIZE_W-1:0] size_reg,   size_next;
    logic [ADDR_W-1:0] base_reg,   base_next;
    logic [SIZE_W-1:0] rcvd_reg,   rcvd_next;
    logic              rel_reg,    rel_next;

    // result queue
    result_t             res_q [RES_DEPTH];
    logic [RES_PTR_W-1:0] wr_ptr_reg;
    logic [RES_PTR_W-1:0] rd_ptr_reg;
    logic [RES_CNT_W-1:0] count_reg;

    // per-byte results
    result_t    r0, r1;
    logic       two_res;

    logic in_xfer;
    logic out_xfer;

    // ------------------------------------------------------------------
    // byte decode shared by next-state and result logic
    // ------------------------------------------------------------------
    logic              is_lf;
    logic              is_dec;
    logic              is_lhex;
    logic              is_uhex;
    logic              is_hex;
    logic [3:0]        hex_val;
    logic [3:0]        dec_val;
    logic [CNT_W-1:0]  cnt_inc;
    logic [SIZE_W-1:0] size_mul;
    logic [SIZE_W-1:0] size_val;
    logic              size_end;
    logic [ADDR_W:0]   end_sum;
    logic              in1, in2, overlap;
    logic [ADDR_W-1:0] new_base;
    logic [SIZE_W-1:0] rcvd_inc;
    logic              img_done;
    logic [ADDR_W-1:0] wr_addr;

    assign is_lf   = (rx_byte == CHAR_LF);
    assign is_dec  = (rx_byte >= 8'h30) && (rx_byte <= 8'h39);
    assign is_lhex = (rx_byte >= 8'h61) && (rx_byte <= 8'h66);
    assign is_uhex = (rx_byte >= 8'h41) && (rx_byte <= 8'h46);
    assign is_hex  = is_dec || is_lhex || is_uhex;
    assign dec_val = rx_byte[3:0];

    always_comb
    begin
        if (is_dec)
            hex_val = rx_byte[3:0];
        else
            hex_val = 4'(rx_byte[2:0] + 3'd1) + 4'd8;   // 'a'/'A' are xx1, so +9
    end

    assign cnt_inc  = cnt_reg + CNT_W'(1);
    // size * 10 + digit as shift-add, wrapping at 27 bits
    assign size_mul = {size_reg[SIZE_W-4:0], 3'b000} + {size_reg[SIZE_W-2:0], 1'b0}
                    + SIZE_W'(dec_val);
    assign size_val = is_lf ? size_reg : size_mul;
    assign size_end = is_lf || (is_dec && (cnt_inc >= CNT_W'(SIZE_DIGITS)));

    // overlap test, end address formed without wrap
    assign end_sum  = {1'b0, addr_reg} + (ADDR_W + 1)'(size_val);
    assign in1      = (addr_reg >= res_start_reg) && (addr_reg <= res_end_reg);
    assign in2      = (end_sum >= {1'b0, res_start_reg}) && (end_sum <= {1'b0, res_end_reg});
    assign overlap  = in1 || in2;
    assign new_base = overlap ? reloc_reg : addr_reg;

    // image stream
    assign rcvd_inc = rcvd_reg + SIZE_W'(1);
    assign img_done = (rcvd_inc >= size_reg);
    assign wr_addr  = base_reg + ADDR_W'(rcvd_reg);

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        size_next  = size_reg;
        base_next  = base_reg;
        rcvd_next  = rcvd_reg;
        rel_next   = rel_reg;
        unique case (phase_reg)
            PH_IMAGE:
            begin
                rcvd_next = rcvd_inc;
                if (img_done)
                begin
                    phase_next = PH_ADDR;
                    cnt_next   = '0;
                    addr_next  = '0;
                    size_next  = '0;
                    base_next  = '0;
                    rcvd_next  = '0;
                    rel_next   = 1'b0;
                end
            end
            PH_SIZE:
            begin
                if (!is_lf && !is_dec)
                begin
                    // bad digit: back to address phase
                    phase_next = PH_ADDR;
                    cnt_next   = '0;
                    addr_next  = '0;
                    size_next  = '0;
                    base_next  = '0;
                    rcvd_next  = '0;
                    rel_next   = 1'b0;
                end
                else if (size_end && (size_val == '0))
                begin
                    // zero-length image starts at once
                    phase_next = PH_ADDR;
                    cnt_next   = '0;
                    addr_next  = '0;
                    size_next  = '0;
                    base_next  = '0;
                    rcvd_next  = '0;
                    rel_next   = 1'b0;
                end
                else if (size_end)
                begin
                    phase_next = PH_IMAGE;
                    cnt_next   = '0;
                    size_next  = size_val;
                    base_next  = new_base;
                    rcvd_next  = '0;
                    rel_next   = overlap;
                end
                else
                begin
                    size_next = size_mul;
                    cnt_next  = cnt_inc;
                end
            end
            default:
            begin
                // address phase, also covers the unused phase code
                phase_next = PH_ADDR;
                if (is_lf)
                begin
                    phase_next = PH_SIZE;
                    cnt_next   = '0;
                    size_next  = '0;
                end
                else if (is_hex)
                begin
                    addr_next = {addr_reg[ADDR_W-5:0], hex_val};
                    cnt_next  = cnt_inc;
                    if (cnt_inc >= CNT_W'(ADDR_DIGITS))
                    begin
                        phase_next = PH_SIZE;
                        cnt_next   = '0;
                        size_next  = '0;
                    end
                end
                else
                begin
                    cnt_next  = '0;
                    addr_next = '0;
                    size_next = '0;
                    base_next = '0;
                    rcvd_next = '0;
                    rel_next  = 1'b0;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // results caused by the current byte
    // ------------------------------------------------------------------
    always_comb
    begin
        r0      = '{kind: EV_ECHO, data: rx_byte, addr: '0, rel: 1'b0, last: 1'b1};
        r1      = '{kind: EV_ERROR, data: rx_byte, addr: '0, rel: 1'b0, last: 1'b1};
        two_res = 1'b0;
        unique case (phase_reg)
            PH_IMAGE:
            begin
                r0 = '{kind: EV_WRITE, data: rx_byte, addr: wr_addr, rel: rel_reg,
                       last: !img_done};
                r1 = '{kind: EV_START, data: 8'h00, addr: base_reg, rel: rel_reg,
                       last: 1'b1};
                two_res = img_done;
            end
            PH_SIZE:
            begin
                if (!is_lf && !is_dec)
                begin
                    r0.last = 1'b0;
                    two_res = 1'b1;
                end
                else if (size_end && (size_val == '0))
                begin
                    r0.last = 1'b0;
                    r1      = '{kind: EV_START, data: 8'h00, addr: new_base, rel: overlap,
                                last: 1'b1};
                    two_res = 1'b1;
                end
            end
            default:
            begin
                if (!is_lf && !is_hex)
                begin
                    r0.last = 1'b0;
                    two_res = 1'b1;
                end
            end
        endcase
    end

    // ------------------------------------------------------------------
    // handshakes: input waits while the queue lacks room for two results
    // ------------------------------------------------------------------
    assign in_stall  = (count_reg > RES_CNT_W'(RES_DEPTH - 2));
    assign in_xfer   = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign out_xfer  = out_valid && !out_stall;

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_start_reg <= '0;
            res_end_reg   <= '0;
            reloc_reg     <= RELOC_DEFAULT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RES_START: res_start_reg <= cfg_data;
                CFG_RES_END:   res_end_reg   <= cfg_data;
                CFG_RELOC:     reloc_reg     <= cfg_data;
                default:       ;
            endcase
        end
    end

    // parser state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ADDR;
            cnt_reg   <= '0;
            addr_reg  <= '0;
            size_reg  <= '0;
            base_reg  <= '0;
            rcvd_reg  <= '0;
            rel_reg   <= 1'b0;
        end
        else if (in_xfer)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            addr_reg  <= addr_next;
            size_reg  <= size_next;
            base_reg  <= base_next;
            rcvd_reg  <= rcvd_next;
            rel_reg   <= rel_next;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_xfer)
                wr_ptr_reg <= wr_ptr_reg + (two_res ? RES_PTR_W'(2) : RES_PTR_W'(1));
            if (out_xfer)
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_W'(1);
            count_reg <= count_reg
                       + (in_xfer ? (two_res ? RES_CNT_W'(2) : RES_CNT_W'(1)) : '0)
                       - (out_xfer ? RES_CNT_W'(1) : '0);
        end
    end

    // queue entries, no reset
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            res_q[wr_ptr_reg] <= r0;
            if (two_res)
                res_q[wr_ptr_reg + RES_PTR_W'(1)] <= r1;
        end
    end

    // head of queue drives the result ports
    assign event_kind  = res_q[rd_ptr_reg].kind;
    assign data_byte   = res_q[rd_ptr_reg].data;
    assign target_addr = res_q[rd_ptr_reg].addr;
    assign relocated   = res_q[rd_ptr_reg].rel;
    assign last_of_run = res_q[rd_ptr_reg].last;

endmodule
